>>> sv/lirp_pkg.sv
// Shared types, codes and constants for the lazy interrupt replay prioritizer.
package lirp_pkg;

  // Latch bit positions
  localparam int unsigned BitHarddis = 0;
  localparam int unsigned BitDec     = 1;
  localparam int unsigned BitEe      = 2;
  localparam int unsigned BitDbell   = 3;
  localparam int unsigned BitPmi     = 4;
  localparam int unsigned BitHmi     = 5;
  localparam int unsigned BitEeedge  = 6;

  localparam int unsigned LatchW  = 7;
  localparam int unsigned VectorW = 12;
  localparam int unsigned TimeW   = 64;
  localparam int unsigned InDataW  = 144;
  localparam int unsigned OutDataW = 24;

  // Replay vectors
  localparam logic [VectorW-1:0] VecHmi      = 12'he60;
  localparam logic [VectorW-1:0] VecDec      = 12'h900;
  localparam logic [VectorW-1:0] VecPmi      = 12'hf00;
  localparam logic [VectorW-1:0] VecEe       = 12'h500;
  localparam logic [VectorW-1:0] VecDbellB3e = 12'h280;
  localparam logic [VectorW-1:0] VecDbell    = 12'ha00;
  localparam logic [VectorW-1:0] VecNone     = 12'h000;

  // Wake reason codes
  localparam logic [3:0] ReasonDbellA = 4'd3;
  localparam logic [3:0] ReasonSreset = 4'd4;
  localparam logic [3:0] ReasonDbellB = 4'd5;
  localparam logic [3:0] ReasonDec    = 4'd6;
  localparam logic [3:0] ReasonEeA    = 4'd8;
  localparam logic [3:0] ReasonEeB    = 4'd9;
  localparam logic [3:0] ReasonHmi    = 4'd10;

  typedef enum logic [2:0] {
    ACT_RAISE   = 3'd0,
    ACT_WAKE    = 3'd1,
    ACT_REPLAY  = 3'd2,
    ACT_IDLE    = 3'd3,
    ACT_HARDDIS = 3'd4
  } action_t;

  typedef struct packed {
    logic [2:0]        action;
    logic [LatchW-1:0] event_bits;
    logic [3:0]        wake_reason;
    logic [TimeW-1:0]  time_now;
    logic [TimeW-1:0]  time_deadline;
  } item_t;

  typedef struct packed {
    logic [VectorW-1:0] vector;
    logic               system_reset;
    logic               idle_ok;
    logic [LatchW-1:0]  pending_after;
    logic               leftover_error;
  } result_t;

  // Map a wake reason to the latch bits it raises
  function automatic logic [LatchW-1:0] wake_bits(input logic [3:0] reason);
    logic [LatchW-1:0] bits;
    bits = '0;
    case (reason)
      ReasonDbellA, ReasonDbellB: bits[BitDbell] = 1'b1;
      ReasonDec:                  bits[BitDec]   = 1'b1;
      ReasonEeA, ReasonEeB:       bits[BitEe]    = 1'b1;
      ReasonHmi:                  bits[BitHmi]   = 1'b1;
      default:                    bits = '0;
    endcase
    return bits;
  endfunction

endpackage

>>> sv/lirp_core.sv
// Pending latch, mode register and the per-transaction action logic.
module lirp_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic             cfg_wr_data,
  input  logic             step,
  input  lirp_pkg::item_t  item,
  output lirp_pkg::result_t result
);
  import lirp_pkg::*;

  logic [LatchW-1:0] latch_r, latch_nxt;
  logic              book3e_r;
  logic [LatchW-1:0] rep;
  logic [LatchW-1:0] rep_cleared;
  logic [VectorW-1:0] vec;
  logic              hit;
  logic              sreset;
  logic              idle;
  logic              err;
  logic              deadline_hit;

  // Decrementer deadline passed
  assign deadline_hit = (item.time_now >= item.time_deadline);

  // Replay: resolve hard-disable, then pick the highest-priority bit
  always_comb begin
    rep = latch_r;
    if (latch_r[BitHarddis]) begin
      rep[BitHarddis] = 1'b0;
      if (!latch_r[BitDec] && deadline_hit) begin
        rep[BitDec] = 1'b1;
      end
    end
    rep_cleared = rep;
    hit = 1'b1;
    vec = VecNone;
    if (rep[BitHmi]) begin
      vec = VecHmi;
      rep_cleared[BitHmi] = 1'b0;
    end else if (rep[BitDec]) begin
      vec = VecDec;
      rep_cleared[BitDec] = 1'b0;
    end else if (rep[BitPmi]) begin
      vec = VecPmi;
      rep_cleared[BitPmi] = 1'b0;
    end else if (rep[BitEe]) begin
      vec = VecEe;
      rep_cleared[BitEe] = 1'b0;
    end else if (book3e_r && rep[BitEeedge]) begin
      vec = VecEe;
      rep_cleared[BitEeedge] = 1'b0;
    end else if (rep[BitDbell]) begin
      vec = book3e_r ? VecDbellB3e : VecDbell;
      rep_cleared[BitDbell] = 1'b0;
    end else begin
      hit = 1'b0;
    end
  end

  // Action decode
  always_comb begin
    latch_nxt = latch_r;
    sreset    = 1'b0;
    idle      = 1'b0;
    err       = 1'b0;
    result.vector = VecNone;
    case (action_t'(item.action))
      ACT_RAISE: begin
        latch_nxt = latch_r | item.event_bits;
      end
      ACT_WAKE: begin
        if (item.wake_reason == ReasonSreset) begin
          sreset = 1'b1;
        end else begin
          latch_nxt = latch_r | wake_bits(item.wake_reason);
        end
      end
      ACT_REPLAY: begin
        latch_nxt = rep_cleared;
        result.vector = vec;
        err = !hit && (rep != '0);
      end
      ACT_IDLE: begin
        if ((latch_r & ~(LatchW'(1) << BitHarddis)) == '0) begin
          latch_nxt = '0;
          idle = 1'b1;
        end else begin
          latch_nxt = latch_r | (LatchW'(1) << BitHarddis);
        end
      end
      ACT_HARDDIS: begin
        latch_nxt = latch_r | (LatchW'(1) << BitHarddis);
      end
      default: begin
        latch_nxt = latch_r;
      end
    endcase
    result.system_reset   = sreset;
    result.idle_ok        = idle;
    result.pending_after  = latch_nxt;
    result.leftover_error = err;
  end

  // Hold latch and mode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_r  <= '0;
      book3e_r <= 1'b0;
    end else begin
      if (step) begin
        latch_r <= latch_nxt;
      end
      if (cfg_wr_en) begin
        book3e_r <= cfg_wr_data;
      end
    end
  end

endmodule

>>> sv/lazy_irq_replay_prioritizer.sv
// Top level: input register, action logic and result register.
//
// Each transaction performs one action on a 7-bit pending-interrupt latch and
// returns one result. The block takes one transaction per clock cycle unless
// the result side stalls; each is held in the input register, then the action
// logic (latch update, priority pick and the 64-bit deadline compare) settles
// into the result register. Both stages stall together when the result is not
// taken; a new transaction is still accepted while a result waits, as long as
// the input register is free or moving. The user must write book3e_mode only
// (cfg_wr_en/cfg_wr_data) while the block is idle; the block does not check.
module lazy_irq_replay_prioritizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,   // book3e_mode
  input  logic        in_tvalid,
  output logic        in_tready,
  // action[2:0] event_bits[9:3] wake_reason[13:10] time_now[77:14]
  // time_deadline[141:78], zero fill [143:142]
  input  logic [143:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // vector[11:0] system_reset[12] idle_ok[13] pending_after[20:14]
  // leftover_error[21], zero fill [23:22]
  output logic [23:0] out_tdata
);
  import lirp_pkg::*;

  logic    s1_valid_r;
  item_t   s1_item_r;
  logic    out_valid_r;
  result_t out_res_r;
  result_t res;
  logic    advance;
  logic    step;
  item_t   in_item;

  // Unpack the input transaction
  assign in_item.action        = in_tdata[2:0];
  assign in_item.event_bits    = in_tdata[9:3];
  assign in_item.wake_reason   = in_tdata[13:10];
  assign in_item.time_now      = in_tdata[77:14];
  assign in_item.time_deadline = in_tdata[141:78];

  // Pipeline control
  assign advance   = !out_valid_r || out_tready;
  assign step      = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;

  lirp_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (step),
    .item        (s1_item_r),
    .result      (res)
  );

  // Advance input and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_item_r <= in_item;
    end
    if (step) begin
      out_res_r <= res;
    end
  end

  // Pack the result transaction
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r.leftover_error, out_res_r.pending_after,
                       out_res_r.idle_ok, out_res_r.system_reset, out_res_r.vector};

endmodule

>>> sv/lirp_checker.sv
// Port-level checks for the lazy interrupt replay prioritizer, with bind.
module lirp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // Nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // A replayed vector excludes the system-reset, idle and leftover-error flags
  a_vec_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[11:0] != 12'h000 |-> !out_tdata[12] && !out_tdata[13] &&
      !out_tdata[21])
    else $error("vector with other flags");

  // Leftover error means no vector and a nonempty latch
  a_leftover: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[21] |-> out_tdata[11:0] == 12'h000 &&
      out_tdata[20:14] != 7'h00)
    else $error("leftover error inconsistent");

  // Idle allowed only with an empty latch
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[13] |-> out_tdata[20:14] == 7'h00)
    else $error("idle allowed with pending bits");

endmodule

bind lazy_irq_replay_prioritizer lirp_checker u_lirp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> dv/lazy_irq_replay_prioritizer_test.sv
// Testbench for the lazy interrupt replay prioritizer: stream stimulus and a checking scoreboard.
`timescale 1ns / 100ps

import lirp_pkg::*;

// Track the pending-interrupt latch and hold the results it should produce
class replay_scoreboard;
  logic [LatchW-1:0] latch;
  logic              book3e;
  result_t           expected_q[$];
  int unsigned       errors;
  int unsigned       items;
  int unsigned       results;
  int unsigned       vectors;
  int unsigned       idle_granted;
  int unsigned       idle_refused;
  int unsigned       sresets;
  int unsigned       leftovers;
  int unsigned       mode_items[2];

  function new();
    latch  = '0;
    book3e = 1'b0;
  endfunction

  // Print one line per mismatch and count it
  task flag_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    errors++;
  endtask

  // Latch bits raised by a wake reason; system reset raises none
  function logic [LatchW-1:0] reason_bits(input logic [3:0] reason);
    logic [LatchW-1:0] bits;
    bits = '0;
    if (reason == ReasonDbellA || reason == ReasonDbellB) bits[BitDbell] = 1'b1;
    else if (reason == ReasonDec) bits[BitDec] = 1'b1;
    else if (reason == ReasonEeA || reason == ReasonEeB) bits[BitEe] = 1'b1;
    else if (reason == ReasonHmi) bits[BitHmi] = 1'b1;
    return bits;
  endfunction

  // Apply one accepted transaction to the latch and queue its result
  function void note_input(input logic [2:0] act, input logic [LatchW-1:0] ev,
                           input logic [3:0] reason, input logic [TimeW-1:0] now,
                           input logic [TimeW-1:0] deadline);
    result_t           res;
    logic [LatchW-1:0] others;
    res = '0;
    case (act)
      ACT_RAISE: latch = latch | ev;
      ACT_WAKE: begin
        if (reason == ReasonSreset) res.system_reset = 1'b1;
        else latch = latch | reason_bits(reason);
      end
      ACT_REPLAY: begin
        // resolve a decrementer deadline missed while hard-disabled
        if (latch[BitHarddis]) begin
          latch[BitHarddis] = 1'b0;
          if (!latch[BitDec] && now >= deadline) latch[BitDec] = 1'b1;
        end
        // pick the highest-priority pending bit and clear only that one
        res.vector = VecNone;
        if (latch[BitHmi]) begin
          res.vector = VecHmi;
          latch[BitHmi] = 1'b0;
        end else if (latch[BitDec]) begin
          res.vector = VecDec;
          latch[BitDec] = 1'b0;
        end else if (latch[BitPmi]) begin
          res.vector = VecPmi;
          latch[BitPmi] = 1'b0;
        end else if (latch[BitEe]) begin
          res.vector = VecEe;
          latch[BitEe] = 1'b0;
        end else if (book3e && latch[BitEeedge]) begin
          res.vector = VecEe;
          latch[BitEeedge] = 1'b0;
        end else if (latch[BitDbell]) begin
          res.vector = book3e ? VecDbellB3e : VecDbell;
          latch[BitDbell] = 1'b0;
        end
        if (res.vector == VecNone && latch != '0) res.leftover_error = 1'b1;
      end
      ACT_IDLE: begin
        // refuse idle while anything besides hard-disable is pending
        latch[BitHarddis] = 1'b1;
        others = latch;
        others[BitHarddis] = 1'b0;
        if (others == '0) begin
          latch[BitHarddis] = 1'b0;
          res.idle_ok = 1'b1;
        end
      end
      ACT_HARDDIS: latch[BitHarddis] = 1'b1;
      default: ;
    endcase
    res.pending_after = latch;
    expected_q.push_back(res);
    items++;
    mode_items[book3e]++;
    if (res.vector != VecNone) vectors++;
    if (act == ACT_IDLE && res.idle_ok) idle_granted++;
    if (act == ACT_IDLE && !res.idle_ok) idle_refused++;
    if (res.system_reset) sresets++;
    if (res.leftover_error) leftovers++;
  endfunction

  // Compare one accepted result with the oldest expectation
  task check_result(input logic [OutDataW-1:0] data);
    result_t got;
    result_t exp_res;
    got.vector         = data[11:0];
    got.system_reset   = data[12];
    got.idle_ok        = data[13];
    got.pending_after  = data[20:14];
    got.leftover_error = data[21];
    results++;
    if (expected_q.size() == 0) begin
      flag_mismatch($sformatf("result with nothing expected: %h", data));
    end else begin
      exp_res = expected_q.pop_front();
      if (got.vector !== exp_res.vector)
        flag_mismatch($sformatf("vector %h, expected %h", got.vector, exp_res.vector));
      if (got.system_reset !== exp_res.system_reset)
        flag_mismatch($sformatf("system_reset %b, expected %b",
                                got.system_reset, exp_res.system_reset));
      if (got.idle_ok !== exp_res.idle_ok)
        flag_mismatch($sformatf("idle_ok %b, expected %b", got.idle_ok, exp_res.idle_ok));
      if (got.pending_after !== exp_res.pending_after)
        flag_mismatch($sformatf("pending_after %b, expected %b",
                                got.pending_after, exp_res.pending_after));
      if (got.leftover_error !== exp_res.leftover_error)
        flag_mismatch($sformatf("leftover_error %b, expected %b",
                                got.leftover_error, exp_res.leftover_error));
    end
  endtask
endclass

module lazy_irq_replay_prioritizer_test;

  localparam int unsigned WatchdogLimit = 400;
  localparam int unsigned SettleCycles  = 4;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_wr_en;
  logic                cfg_wr_data;
  logic                in_tvalid;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata;
  logic                out_tvalid;
  logic                out_tready;
  logic [OutDataW-1:0] out_tdata;

  replay_scoreboard sb;
  bit               gaps_on;
  int unsigned      sent;
  int unsigned      quiet_cycles;

  lazy_irq_replay_prioritizer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #6 clk = ~clk;

  // Record transactions on both channels and watch for a stall
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      sb.note_input(in_tdata[2:0], in_tdata[9:3], in_tdata[13:10], in_tdata[77:14],
                    in_tdata[141:78]);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("timeout after %0d cycles without a transaction", quiet_cycles);
        $display("lazy_irq_replay_prioritizer verification failed");
        $finish;
      end
    end
  end

  // Stall the result side in random bursts
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end
      out_tready = 1'b1;
    end
  end

  // Drive one transaction and hold it until accepted
  task automatic send_item(input logic [2:0] act, input logic [LatchW-1:0] ev,
                           input logic [3:0] reason, input logic [TimeW-1:0] now,
                           input logic [TimeW-1:0] deadline);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {2'b00, deadline, now, reason, ev, act};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    sent++;
  endtask

  // Stop sending and let every outstanding result come back
  task automatic drain();
    in_tvalid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // Write book3e_mode while the block is idle
  task automatic write_mode(input logic mode);
    drain();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = mode;
    sb.book3e   = mode;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // Choose a timebase pair, leaning on the compare boundaries
  task automatic pick_times(output logic [TimeW-1:0] now, output logic [TimeW-1:0] deadline);
    deadline = {$urandom, $urandom};
    case ($urandom_range(0, 6))
      0: now = deadline;
      1: now = deadline + 1;
      2: now = deadline - 1;
      3: begin
        now      = '0;
        deadline = '1;
      end
      4: begin
        now      = '1;
        deadline = '0;
      end
      default: now = {$urandom, $urandom};
    endcase
  endtask

  // Send one transaction of a weighted random action
  task automatic send_random_item();
    logic [TimeW-1:0]  now;
    logic [TimeW-1:0]  deadline;
    logic [LatchW-1:0] ev;
    logic [2:0]        act;
    pick_times(now, deadline);
    ev = ($urandom_range(0, 2) == 0) ? LatchW'($urandom) : LatchW'($urandom & $urandom);
    case ($urandom_range(0, 9))
      0, 1:    act = ACT_RAISE;
      2, 3:    act = ACT_WAKE;
      4, 5, 6: act = ACT_REPLAY;
      7, 8:    act = ACT_IDLE;
      default: act = ACT_HARDDIS;
    endcase
    send_item(act, ev, 4'($urandom_range(0, 15)), now, deadline);
  endtask

  // Raise some events, maybe hard-disable, replay one to six times, then maybe try idle
  task automatic send_sequence();
    logic [TimeW-1:0] now;
    logic [TimeW-1:0] deadline;
    int unsigned      n;
    n = $urandom_range(1, 3);
    repeat (n) begin
      pick_times(now, deadline);
      if ($urandom_range(0, 1) == 0)
        send_item(ACT_RAISE, LatchW'($urandom & $urandom), '0, now, deadline);
      else
        send_item(ACT_WAKE, '0, 4'($urandom_range(0, 15)), now, deadline);
    end
    if ($urandom_range(0, 1) == 0) begin
      pick_times(now, deadline);
      send_item(ACT_HARDDIS, LatchW'($urandom), 4'($urandom), now, deadline);
    end
    repeat ($urandom_range(1, 6)) begin
      pick_times(now, deadline);
      send_item(ACT_REPLAY, LatchW'($urandom), 4'($urandom), now, deadline);
    end
    if ($urandom_range(0, 1) == 0) begin
      pick_times(now, deadline);
      send_item(ACT_IDLE, LatchW'($urandom), 4'($urandom), now, deadline);
    end
  endtask

  // Mostly well-formed sequences, some single random transactions
  task automatic random_phase(input int unsigned count, input bit pause_once);
    int unsigned target;
    bit          paused;
    target = sent + count;
    paused = 1'b0;
    while (sent < target) begin
      if ($urandom_range(0, 9) < 7) send_sequence();
      else send_random_item();
      if (pause_once && !paused && sent >= target - count / 2) begin
        drain();
        paused = 1'b1;
      end
    end
  endtask

  // Directed cases: empty latch, full latch, every default-mode vector, leftover, idle, wake reasons
  task automatic directed_mode0();
    logic [TimeW-1:0] t;
    t = {$urandom, $urandom};
    send_item(ACT_REPLAY, '0, '0, '0, '0);
    send_item(ACT_IDLE, '0, '0, t, t);
    send_item(ACT_RAISE, '1, '1, '1, '1);
    send_item(ACT_REPLAY, '0, '0, '1, '0);
    send_item(ACT_REPLAY, '0, '0, '1, '0);
    send_item(ACT_REPLAY, '0, '0, t, t);
    send_item(ACT_REPLAY, '0, '0, t, t);
    send_item(ACT_REPLAY, '0, '0, t, t);
    send_item(ACT_REPLAY, '0, '0, t, t);
    send_item(ACT_IDLE, '0, '0, t, t);
    send_item(ACT_REPLAY, '0, '0, t, t);
    send_item(ACT_HARDDIS, '0, '0, t, t);
    send_item(ACT_REPLAY, '0, '0, '0, '1);
    send_item(ACT_WAKE, '0, ReasonSreset, t, t);
    send_item(ACT_WAKE, '0, ReasonDbellA, t, t);
    send_item(ACT_WAKE, '0, ReasonDbellB, t, t);
    send_item(ACT_WAKE, '0, ReasonDec, t, t);
    send_item(ACT_WAKE, '0, ReasonEeA, t, t);
    send_item(ACT_WAKE, '0, ReasonEeB, t, t);
    send_item(ACT_WAKE, '0, ReasonHmi, t, t);
    send_item(ACT_WAKE, '0, 4'd0, t, t);
    send_item(ACT_WAKE, '0, 4'd15, t, t);
  endtask

  // Book3e vectors: EE-edge replay and the alternate doorbell vector
  task automatic directed_mode1();
    send_item(ACT_RAISE, 7'h48, '0, '0, '0);
    send_item(ACT_REPLAY, '0, '0, '0, '0);
    send_item(ACT_REPLAY, '0, '0, '0, '0);
  endtask

  initial begin
    sb          = new();
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    gaps_on     = 1'b1;
    sent        = 0;
    quiet_cycles = 0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    write_mode(1'b0);
    directed_mode0();
    write_mode(1'b1);
    directed_mode1();
    random_phase(150, 1'b1);
    write_mode(1'b0);
    random_phase(150, 1'b0);
    write_mode(1'b1);
    gaps_on = 1'b0;
    random_phase(150, 1'b0);

    // Wait out every expected result and let the block settle
    drain();

    $display("covered %0d transactions (%0d in book3e mode, %0d in default mode), %0d results",
             sb.items, sb.mode_items[1], sb.mode_items[0], sb.results);
    $display("replayed %0d vectors; idle granted %0d, refused %0d; %0d system resets, %0d leftovers",
             sb.vectors, sb.idle_granted, sb.idle_refused, sb.sresets, sb.leftovers);
    if (sb.errors == 0) begin
      $display("lazy_irq_replay_prioritizer verification clean");
    end else begin
      $display("lazy_irq_replay_prioritizer verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
sv/lirp_pkg.sv
sv/lirp_core.sv
sv/lazy_irq_replay_prioritizer.sv
sv/lirp_checker.sv
dv/lazy_irq_replay_prioritizer_test.sv
